// ===== hw/rtl/iba_pkg.sv =====
// Shared types and constants of the indexed block allocator.
package iba_pkg;

    localparam int ACT_W    = 3;
    localparam int ID_W     = 16;
    localparam int SIZE_W   = 16;
    localparam int BLK_W    = 6;
    localparam int STAT_W   = 2;
    localparam int LFSR_W   = 16;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD       = 3'd0,
        ACT_DELETE    = 3'd1,
        ACT_SEEK      = 3'd2,
        ACT_LIST_FILE = 3'd3,
        ACT_LIST_OCC  = 3'd4,
        ACT_CLEAR     = 3'd5
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OSEL_NONE,
        OSEL_POS,
        OSEL_IDX,
        OSEL_SCAN
    } t_osel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_RD,
        S_FIND_CMP,
        S_ADD_CHK,
        S_LFSR,
        S_MUL,
        S_MOD,
        S_SEARCH,
        S_ADD_DONE,
        S_DEL_RD,
        S_DEL_CLR,
        S_DEL_IB,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DEL_DONE,
        S_SEEK_CHK,
        S_SEEK_EMIT,
        S_LF_RD,
        S_LF_EMIT,
        S_LO_SCAN,
        S_OK,
        S_REJ,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic    load_req;
        logic    dir_rd;
        logic    dir_prev;
        logic    find_next;
        logic    find_hit;
        logic    add_setup;
        logic    lfsr_step;
        logic    mul;
        logic    modr;
        logic    search_next;
        logic    claim;
        logic    add_commit;
        logic    idx_rd;
        logic    idx_seek;
        logic    del_free;
        logic    del_ib;
        logic    shift_setup;
        logic    shift_wr;
        logic    del_done;
        logic    lf_setup;
        logic    idec;
        logic    lo_setup;
        logic    lo_step;
        logic    lo_count;
        logic    clear;
        logic    emit;
        t_status status;
        t_osel   osel;
        logic    last;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    dir_full;
        logic    find_end;
        logic    key_match;
        logic    space_ok;
        logic    occ_here;
        logic    alloc_last;
        logic    seek_ok;
        logic    del_end;
        logic    shift_end;
        logic    list_last;
        logic    list_empty;
        logic    scan_occ;
        logic    lo_last;
        logic    used_zero;
        logic    out_free;
    } t_sts;

endpackage

// ===== hw/rtl/iba_if.sv =====
// Handshake channel interfaces of the indexed block allocator.
interface iba_req_if;
    logic                        valid;
    logic                        ready;
    logic [iba_pkg::ACT_W-1:0]   action;
    logic [iba_pkg::ID_W-1:0]    file_id;
    logic [iba_pkg::SIZE_W-1:0]  file_size;
    logic [iba_pkg::BLK_W-1:0]   block_number;
    modport source (output valid, action, file_id, file_size, block_number, input ready);
    modport sink   (input valid, action, file_id, file_size, block_number, output ready);
endinterface

interface iba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [iba_pkg::STAT_W-1:0]  status;
    logic [iba_pkg::BLK_W-1:0]   block_index;
    logic [iba_pkg::ID_W-1:0]    file_out;
    logic                        last;
    modport source (output valid, status, block_index, file_out, last, input ready);
    modport sink   (input valid, status, block_index, file_out, last, output ready);
endinterface

interface iba_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [iba_pkg::LFSR_W-1:0]  lfsr_seed;
    modport source (output valid, lfsr_seed, input ready);
    modport sink   (input valid, lfsr_seed, output ready);
endinterface

// ===== hw/rtl/iba_datapath.sv =====
// Datapath: bitmap, directory and index memories, LFSR, counters, result register.
module iba_datapath #(
    parameter int NUM_BLOCKS    = 64,
    parameter int MAX_DIR_FILES = 16,
    parameter int BLOCK_KIB     = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [iba_pkg::ACT_W-1:0]   i_action,
    input  logic [iba_pkg::ID_W-1:0]    i_file_id,
    input  logic [iba_pkg::SIZE_W-1:0]  i_file_size,
    input  logic [iba_pkg::BLK_W-1:0]   i_block_number,
    input  logic                        i_cfg_fire,
    input  logic [iba_pkg::LFSR_W-1:0]  i_cfg_seed,
    input  iba_pkg::t_cmd               i_cmd,
    output iba_pkg::t_sts               o_sts,
    input  logic                        i_rsp_ready,
    output logic                        o_rsp_valid,
    output logic [iba_pkg::STAT_W-1:0]  o_status,
    output logic [iba_pkg::BLK_W-1:0]   o_block_index,
    output logic [iba_pkg::ID_W-1:0]    o_file_out,
    output logic                        o_last
);

    localparam int IDX_W    = $clog2(NUM_BLOCKS);
    localparam int ST_DEPTH = NUM_BLOCKS * (NUM_BLOCKS - 1);
    localparam int ST_W     = $clog2(ST_DEPTH);
    localparam int DIR_W    = (MAX_DIR_FILES > 1) ? $clog2(MAX_DIR_FILES) : 1;
    localparam int LEN_W    = $clog2(MAX_DIR_FILES + 1);
    localparam int USED_W   = $clog2(NUM_BLOCKS + 1);
    localparam int KIB_W    = $clog2(BLOCK_KIB + 1);
    localparam int CMP_W    = (USED_W + KIB_W > iba_pkg::SIZE_W) ?
                              (USED_W + KIB_W) : iba_pkg::SIZE_W;
    localparam int DENT_W   = iba_pkg::ID_W + 2 * IDX_W;
    localparam int LW       = iba_pkg::LFSR_W;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_BLOCKS);

    // Captured request.
    logic [iba_pkg::ACT_W-1:0]  r_act;
    logic [iba_pkg::ID_W-1:0]   r_id;
    logic [iba_pkg::SIZE_W-1:0] r_size;
    logic [iba_pkg::BLK_W-1:0]  r_bn;

    logic [LW-1:0]          r_lfsr;
    logic [LW-1:0]          r_q;
    logic [IDX_W-1:0]       r_pos;
    logic [NUM_BLOCKS-1:0]  r_occ;
    logic [LEN_W-1:0]       r_len;
    logic [USED_W-1:0]      r_used;
    logic [LEN_W-1:0]       r_i;
    logic [iba_pkg::SIZE_W-1:0] r_rem;
    logic [IDX_W-1:0]       r_k;
    logic [IDX_W-1:0]       r_ib;
    logic                   r_ib_done;
    logic [IDX_W-1:0]       r_cnt;
    logic [ST_W-1:0]        r_base;
    logic [IDX_W-1:0]       r_j;
    logic [IDX_W-1:0]       r_s;
    logic [USED_W-1:0]      r_e;

    logic [DENT_W-1:0]      r_dir_mem [MAX_DIR_FILES];
    logic [DENT_W-1:0]      r_dir_q;
    logic [IDX_W-1:0]       r_idx_mem [ST_DEPTH];
    logic [IDX_W-1:0]       r_idx_q;

    logic                        r_valid;
    logic [iba_pkg::STAT_W-1:0]  r_status;
    logic [iba_pkg::BLK_W-1:0]   r_blk;
    logic [iba_pkg::ID_W-1:0]    r_fout;
    logic                        r_last;

    logic [iba_pkg::ID_W-1:0] dent_key;
    logic [IDX_W-1:0]         dent_ib;
    logic [IDX_W-1:0]         dent_cnt;
    logic [USED_W-1:0]        free_cnt;
    logic [LW-1:0]            lfsr_next;
    logic [LW-1:0]            mod_raw;
    logic [LW-1:0]            mod_fix;
    logic [47:0]              prod;
    logic [DIR_W-1:0]         dir_ra;
    logic [DIR_W-1:0]         dir_wa;
    logic [DENT_W-1:0]        dir_wd;
    logic                     dir_we;
    logic [ST_W-1:0]          idx_ra;
    logic [ST_W-1:0]          idx_wa;
    logic                     idx_we;
    logic                     out_free;

    assign dent_key = r_dir_q[DENT_W-1 -: iba_pkg::ID_W];
    assign dent_ib  = r_dir_q[2*IDX_W-1 -: IDX_W];
    assign dent_cnt = r_dir_q[IDX_W-1:0];
    assign free_cnt = USED_W'(NUM_BLOCKS) - r_used;
    assign out_free = !r_valid || i_rsp_ready;

    // Galois LFSR step and remainder by reciprocal multiplication.
    assign lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ iba_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    assign prod      = 48'(r_lfsr) * 48'(RECIP);
    assign mod_raw   = r_lfsr - LW'(r_q * LW'(NUM_BLOCKS));
    assign mod_fix   = (mod_raw >= LW'(NUM_BLOCKS)) ? (mod_raw - LW'(NUM_BLOCKS)) : mod_raw;

    assign dir_ra = i_cmd.dir_prev ? DIR_W'(r_i - LEN_W'(1)) : DIR_W'(r_i);
    assign dir_we = i_cmd.add_commit || i_cmd.shift_wr;
    assign dir_wa = i_cmd.add_commit ? DIR_W'(r_len) : DIR_W'(r_i - LEN_W'(1));
    assign dir_wd = i_cmd.add_commit ? {r_id, r_ib, r_k} : r_dir_q;

    assign idx_we = i_cmd.claim && r_ib_done;
    assign idx_wa = r_base + ST_W'(r_k);
    assign idx_ra = r_base + (i_cmd.idx_seek ? ST_W'(r_bn[IDX_W-1:0]) : ST_W'(r_j));

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_wa] <= dir_wd;
        end
        if (i_cmd.dir_rd) begin
            r_dir_q <= r_dir_mem[dir_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (idx_we) begin
            r_idx_mem[idx_wa] <= r_pos;
        end
        if (i_cmd.idx_rd) begin
            r_idx_q <= r_idx_mem[idx_ra];
        end
    end

    // Control state: bitmap, counts, LFSR and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_len   <= '0;
            r_used  <= '0;
            r_lfsr  <= LW'(1);
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_fire) begin
                r_lfsr <= (i_cfg_seed == '0) ? LW'(1) : i_cfg_seed;
            end else if (i_cmd.lfsr_step) begin
                r_lfsr <= lfsr_next;
            end
            if (i_cmd.clear) begin
                r_occ  <= '0;
                r_len  <= '0;
                r_used <= '0;
            end
            if (i_cmd.claim) begin
                r_occ[r_pos] <= 1'b1;
            end
            if (i_cmd.del_free) begin
                r_occ[r_idx_q] <= 1'b0;
                r_used         <= r_used - USED_W'(1);
            end
            if (i_cmd.del_ib) begin
                r_occ[r_ib] <= 1'b0;
                r_used      <= r_used - USED_W'(1);
            end
            if (i_cmd.add_commit) begin
                r_len  <= r_len + LEN_W'(1);
                r_used <= r_used + USED_W'(r_k) + USED_W'(1);
            end
            if (i_cmd.del_done) begin
                r_len <= r_len - LEN_W'(1);
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_act  <= i_action;
            r_id   <= i_file_id;
            r_size <= i_file_size;
            r_bn   <= i_block_number;
        end
        if (i_cmd.load_req) begin
            r_i <= '0;
        end else if (i_cmd.find_next || i_cmd.shift_wr) begin
            r_i <= r_i + LEN_W'(1);
        end else if (i_cmd.shift_setup) begin
            r_i <= r_i + LEN_W'(1);
        end else if (i_cmd.lf_setup) begin
            r_i <= r_len;
        end else if (i_cmd.idec) begin
            r_i <= r_i - LEN_W'(1);
        end
        if (i_cmd.find_hit) begin
            r_ib   <= dent_ib;
            r_cnt  <= dent_cnt;
            r_base <= ST_W'(ST_W'(dent_ib) * ST_W'(NUM_BLOCKS - 1));
            r_j    <= '0;
        end
        if (i_cmd.mul) begin
            r_q <= prod[47:32];
        end
        if (i_cmd.modr) begin
            r_pos <= mod_fix[IDX_W-1:0];
        end else if (i_cmd.search_next) begin
            r_pos <= (r_pos == IDX_W'(NUM_BLOCKS - 1)) ? '0 : r_pos + IDX_W'(1);
        end
        if (i_cmd.add_setup) begin
            r_rem     <= r_size;
            r_k       <= '0;
            r_ib_done <= 1'b0;
        end else if (i_cmd.claim) begin
            if (!r_ib_done) begin
                r_ib      <= r_pos;
                r_ib_done <= 1'b1;
                r_base    <= ST_W'(ST_W'(r_pos) * ST_W'(NUM_BLOCKS - 1));
            end else begin
                r_k   <= r_k + IDX_W'(1);
                r_rem <= (r_rem > iba_pkg::SIZE_W'(BLOCK_KIB)) ?
                         (r_rem - iba_pkg::SIZE_W'(BLOCK_KIB)) : '0;
            end
        end
        if (i_cmd.del_free) begin
            r_j <= r_j + IDX_W'(1);
        end
        if (i_cmd.lo_setup) begin
            r_s <= '0;
            r_e <= '0;
        end else begin
            if (i_cmd.lo_step) begin
                r_s <= r_s + IDX_W'(1);
            end
            if (i_cmd.lo_count) begin
                r_e <= r_e + USED_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_last   <= i_cmd.last;
            r_fout   <= (i_cmd.osel == iba_pkg::OSEL_NONE && i_cmd.status == iba_pkg::ST_OK &&
                         r_act == iba_pkg::ACT_LIST_FILE) ? dent_key : '0;
            case (i_cmd.osel)
                iba_pkg::OSEL_POS:  r_blk <= iba_pkg::BLK_W'(r_pos);
                iba_pkg::OSEL_IDX:  r_blk <= iba_pkg::BLK_W'(r_idx_q);
                iba_pkg::OSEL_SCAN: r_blk <= iba_pkg::BLK_W'(r_s);
                default:            r_blk <= '0;
            endcase
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.act        = iba_pkg::t_action'(r_act);
        o_sts.dir_full   = (r_len == LEN_W'(MAX_DIR_FILES));
        o_sts.find_end   = (r_i == r_len);
        o_sts.key_match  = (dent_key == r_id);
        o_sts.space_ok   = (free_cnt != '0) &&
                           (CMP_W'(r_size) <= CMP_W'(free_cnt - USED_W'(1)) * CMP_W'(BLOCK_KIB));
        o_sts.occ_here   = r_occ[r_pos];
        o_sts.alloc_last = r_ib_done ? (r_rem <= iba_pkg::SIZE_W'(BLOCK_KIB)) : (r_size == '0);
        o_sts.seek_ok    = (r_bn < iba_pkg::BLK_W'(r_cnt));
        o_sts.del_end    = (r_j == r_cnt);
        o_sts.shift_end  = (r_i == r_len);
        o_sts.list_last  = (r_i == LEN_W'(1));
        o_sts.list_empty = (r_len == '0);
        o_sts.scan_occ   = r_occ[r_s];
        o_sts.lo_last    = (r_e + USED_W'(1) == r_used);
        o_sts.used_zero  = (r_used == '0);
        o_sts.out_free   = out_free;
    end

    assign o_rsp_valid   = r_valid;
    assign o_status      = r_status;
    assign o_block_index = r_blk;
    assign o_file_out    = r_fout;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/iba_ctrl.sv =====
// Controller: sequences each request over the datapath.
module iba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  iba_pkg::t_sts i_sts,
    output iba_pkg::t_cmd o_cmd
);

    iba_pkg::t_state r_state;
    iba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = iba_pkg::ST_OK;
        o_cmd.osel   = iba_pkg::OSEL_NONE;
        o_req_ready  = 1'b0;
        case (r_state)
            iba_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = iba_pkg::S_DISPATCH;
                end
            end
            iba_pkg::S_DISPATCH: begin
                case (i_sts.act)
                    iba_pkg::ACT_ADD: begin
                        n_state = i_sts.dir_full ? iba_pkg::S_REJ : iba_pkg::S_FIND_RD;
                    end
                    iba_pkg::ACT_DELETE, iba_pkg::ACT_SEEK: begin
                        n_state = iba_pkg::S_FIND_RD;
                    end
                    iba_pkg::ACT_LIST_FILE: begin
                        if (i_sts.list_empty) begin
                            n_state = iba_pkg::S_EMPTY;
                        end else begin
                            o_cmd.lf_setup = 1'b1;
                            n_state        = iba_pkg::S_LF_RD;
                        end
                    end
                    iba_pkg::ACT_LIST_OCC: begin
                        if (i_sts.used_zero) begin
                            n_state = iba_pkg::S_EMPTY;
                        end else begin
                            o_cmd.lo_setup = 1'b1;
                            n_state        = iba_pkg::S_LO_SCAN;
                        end
                    end
                    iba_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = iba_pkg::S_OK;
                    end
                    default: n_state = iba_pkg::S_REJ;
                endcase
            end
            iba_pkg::S_FIND_RD: begin
                if (i_sts.find_end) begin
                    n_state = (i_sts.act == iba_pkg::ACT_ADD) ? iba_pkg::S_ADD_CHK : iba_pkg::S_REJ;
                end else begin
                    o_cmd.dir_rd = 1'b1;
                    n_state      = iba_pkg::S_FIND_CMP;
                end
            end
            iba_pkg::S_FIND_CMP: begin
                if (i_sts.key_match) begin
                    o_cmd.find_hit = 1'b1;
                    case (i_sts.act)
                        iba_pkg::ACT_DELETE: n_state = iba_pkg::S_DEL_RD;
                        iba_pkg::ACT_SEEK:   n_state = iba_pkg::S_SEEK_CHK;
                        default:             n_state = iba_pkg::S_REJ;
                    endcase
                end else begin
                    o_cmd.find_next = 1'b1;
                    n_state         = iba_pkg::S_FIND_RD;
                end
            end
            iba_pkg::S_ADD_CHK: begin
                if (i_sts.space_ok) begin
                    o_cmd.add_setup = 1'b1;
                    n_state         = iba_pkg::S_LFSR;
                end else begin
                    n_state = iba_pkg::S_REJ;
                end
            end
            iba_pkg::S_LFSR: begin
                o_cmd.lfsr_step = 1'b1;
                n_state         = iba_pkg::S_MUL;
            end
            iba_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = iba_pkg::S_MOD;
            end
            iba_pkg::S_MOD: begin
                o_cmd.modr = 1'b1;
                n_state    = iba_pkg::S_SEARCH;
            end
            iba_pkg::S_SEARCH: begin
                if (i_sts.occ_here) begin
                    o_cmd.search_next = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.claim = 1'b1;
                    o_cmd.emit  = 1'b1;
                    o_cmd.osel  = iba_pkg::OSEL_POS;
                    o_cmd.last  = i_sts.alloc_last;
                    n_state     = i_sts.alloc_last ? iba_pkg::S_ADD_DONE : iba_pkg::S_LFSR;
                end
            end
            iba_pkg::S_ADD_DONE: begin
                o_cmd.add_commit = 1'b1;
                n_state          = iba_pkg::S_IDLE;
            end
            iba_pkg::S_DEL_RD: begin
                if (i_sts.del_end) begin
                    n_state = iba_pkg::S_DEL_IB;
                end else begin
                    o_cmd.idx_rd = 1'b1;
                    n_state      = iba_pkg::S_DEL_CLR;
                end
            end
            iba_pkg::S_DEL_CLR: begin
                o_cmd.del_free = 1'b1;
                n_state        = iba_pkg::S_DEL_RD;
            end
            iba_pkg::S_DEL_IB: begin
                o_cmd.del_ib      = 1'b1;
                o_cmd.shift_setup = 1'b1;
                n_state           = iba_pkg::S_SHIFT_RD;
            end
            iba_pkg::S_SHIFT_RD: begin
                if (i_sts.shift_end) begin
                    n_state = iba_pkg::S_DEL_DONE;
                end else begin
                    o_cmd.dir_rd = 1'b1;
                    n_state      = iba_pkg::S_SHIFT_WR;
                end
            end
            iba_pkg::S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = iba_pkg::S_SHIFT_RD;
            end
            iba_pkg::S_DEL_DONE: begin
                o_cmd.del_done = 1'b1;
                n_state        = iba_pkg::S_OK;
            end
            iba_pkg::S_SEEK_CHK: begin
                if (i_sts.seek_ok) begin
                    o_cmd.idx_rd   = 1'b1;
                    o_cmd.idx_seek = 1'b1;
                    n_state        = iba_pkg::S_SEEK_EMIT;
                end else begin
                    n_state = iba_pkg::S_REJ;
                end
            end
            iba_pkg::S_SEEK_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.osel = iba_pkg::OSEL_IDX;
                    o_cmd.last = 1'b1;
                    n_state    = iba_pkg::S_IDLE;
                end
            end
            iba_pkg::S_LF_RD: begin
                o_cmd.dir_rd   = 1'b1;
                o_cmd.dir_prev = 1'b1;
                n_state        = iba_pkg::S_LF_EMIT;
            end
            iba_pkg::S_LF_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_sts.list_last;
                    o_cmd.idec = 1'b1;
                    n_state    = i_sts.list_last ? iba_pkg::S_IDLE : iba_pkg::S_LF_RD;
                end
            end
            iba_pkg::S_LO_SCAN: begin
                if (!i_sts.scan_occ) begin
                    o_cmd.lo_step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.osel     = iba_pkg::OSEL_SCAN;
                    o_cmd.last     = i_sts.lo_last;
                    o_cmd.lo_step  = 1'b1;
                    o_cmd.lo_count = 1'b1;
                    if (i_sts.lo_last) begin
                        n_state = iba_pkg::S_IDLE;
                    end
                end
            end
            iba_pkg::S_OK, iba_pkg::S_REJ, iba_pkg::S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    case (r_state)
                        iba_pkg::S_REJ:   o_cmd.status = iba_pkg::ST_REJECT;
                        iba_pkg::S_EMPTY: o_cmd.status = iba_pkg::ST_EMPTY;
                        default:          o_cmd.status = iba_pkg::ST_OK;
                    endcase
                    n_state = iba_pkg::S_IDLE;
                end
            end
            default: n_state = iba_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/indexed_block_allocator.sv =====
// Top level of the indexed block allocator: controller plus datapath.
//
//  Channel  Direction  Carries
//  i_req    in         one request: action, file_id, file_size, block_number
//  o_rsp    out        results, at most one per cycle: status, block_index, file_out, last
//  i_cfg    in         lfsr_seed, loads the search-start generator at once
//
// Each request runs alone. An add looks up the directory entry by entry, then claims its
// blocks one at a time, probing past occupied ones; a delete frees each data block and the
// index block, then moves later entries down; list files reads each file and list occupied
// scans the disk blocks in order. Reset is synchronous and active low; it empties the
// bitmap and directory and loads the generator with 1, and the memories need no clearing.
// A stalled result holds the controller only once its next result is ready.
module indexed_block_allocator #(
    parameter int NUM_BLOCKS    = 64,
    parameter int MAX_DIR_FILES = 16,
    parameter int BLOCK_KIB     = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iba_req_if.sink   i_req,
    iba_rsp_if.source o_rsp,
    iba_cfg_if.sink   i_cfg
);

    iba_pkg::t_cmd cmd;
    iba_pkg::t_sts sts;
    logic          req_ready;

    // Configuration writes are to be issued only while the block is idle; the block itself
    // does not enforce this, and the port is always ready.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    iba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iba_datapath #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAX_DIR_FILES (MAX_DIR_FILES),
        .BLOCK_KIB     (BLOCK_KIB)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_req.action),
        .i_file_id      (i_req.file_id),
        .i_file_size    (i_req.file_size),
        .i_block_number (i_req.block_number),
        .i_cfg_fire     (i_cfg.valid),
        .i_cfg_seed     (i_cfg.lfsr_seed),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_block_index  (o_rsp.block_index),
        .o_file_out     (o_rsp.file_out),
        .o_last         (o_rsp.last)
    );

endmodule

// ===== verif/indexed_block_allocator_tb.sv =====
// Self-checking testbench of the indexed block allocator with a built-in allocation predictor.
module indexed_block_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_BLK      = 64;
    localparam int N_DIR      = 16;
    localparam int KIB_PER    = 4;
    localparam int STALL_MAX  = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_CYC  = 100;
    localparam int POOL_SZ    = 24;

    // Action codes outside the defined set; the block must reject them.
    localparam logic [iba_pkg::ACT_W-1:0] ACT_RSVD_LO = 3'd6;
    localparam logic [iba_pkg::ACT_W-1:0] ACT_RSVD_HI = 3'd7;

    typedef struct {
        logic [iba_pkg::ACT_W-1:0]  action;
        logic [iba_pkg::ID_W-1:0]   file_id;
        logic [iba_pkg::SIZE_W-1:0] file_size;
        logic [iba_pkg::BLK_W-1:0]  block_number;
    } t_req_item;

    typedef struct {
        logic [iba_pkg::STAT_W-1:0] status;
        logic [iba_pkg::BLK_W-1:0]  block_index;
        logic [iba_pkg::ID_W-1:0]   file_out;
        logic                       last;
    } t_rsp_item;

    logic i_clk;
    logic i_rst_n;

    iba_req_if req_ch ();
    iba_rsp_if rsp_ch ();
    iba_cfg_if cfg_ch ();

    indexed_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be offered and results the predictor says must come.
    t_req_item pending_reqs[$];
    t_rsp_item expected_rsps[$];

    int unsigned errors;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    logic        hold_start;
    logic        hold_taken;
    logic        req_fire;

    logic [iba_pkg::ID_W-1:0] id_pool[POOL_SZ];

    // Shadow copy of the allocator state.
    logic                       sh_occ[N_BLK];
    logic [iba_pkg::BLK_W-1:0]  sh_index[N_BLK][N_BLK-1];
    int unsigned                sh_count[N_BLK];
    logic [iba_pkg::ID_W-1:0]   sh_key[N_DIR];
    logic [iba_pkg::BLK_W-1:0]  sh_dir_ib[N_DIR];
    int unsigned                sh_dir_len;
    int unsigned                sh_used;
    logic [iba_pkg::LFSR_W-1:0] sh_lfsr;

    task automatic report(string what, int got, int want);
        errors++;
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic void push_rsp(logic [iba_pkg::STAT_W-1:0] st, int blk, int fid, bit lst);
        t_rsp_item r;
        r.status = st;
        r.block_index = blk[iba_pkg::BLK_W-1:0];
        r.file_out = fid[iba_pkg::ID_W-1:0];
        r.last = lst;
        expected_rsps = {expected_rsps, r};
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < N_BLK; i++) begin
            sh_occ[i] = 1'b0;
            sh_count[i] = 0;
        end
        sh_dir_len = 0;
        sh_used = 0;
    endfunction

    // Advance the search-start generator and return the first free block from it.
    function automatic int claim_block();
        logic lsb;
        int start;
        int pick;
        lsb = sh_lfsr[0];
        sh_lfsr = sh_lfsr >> 1;
        if (lsb) begin
            sh_lfsr = sh_lfsr ^ iba_pkg::LFSR_TAPS;
        end
        start = int'(sh_lfsr) % N_BLK;
        pick = start;
        for (int n = 0; n < N_BLK; n++) begin
            if (!sh_occ[(start + n) % N_BLK]) begin
                pick = (start + n) % N_BLK;
                break;
            end
        end
        sh_occ[pick] = 1'b1;
        return pick;
    endfunction

    function automatic int dir_lookup(logic [iba_pkg::ID_W-1:0] id);
        for (int i = 0; i < int'(sh_dir_len); i++) begin
            if (sh_key[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Work out every result that one accepted request causes.
    function automatic void predict_allocation(t_req_item it);
        int pos;
        int ib;
        int blk;
        int lastpos;
        int need;
        case (it.action)
            iba_pkg::ACT_ADD: begin
                need = (int'(it.file_size) + KIB_PER - 1) / KIB_PER;
                if (sh_dir_len >= N_DIR || dir_lookup(it.file_id) >= 0 ||
                        N_BLK - int'(sh_used) < need + 1) begin
                    push_rsp(iba_pkg::ST_REJECT, 0, 0, 1'b1);
                end else begin
                    ib = claim_block();
                    push_rsp(iba_pkg::ST_OK, ib, 0, need == 0);
                    for (int i = 0; i < need; i++) begin
                        blk = claim_block();
                        sh_index[ib][i] = blk[iba_pkg::BLK_W-1:0];
                        push_rsp(iba_pkg::ST_OK, blk, 0, i + 1 == need);
                    end
                    sh_count[ib] = need;
                    sh_key[sh_dir_len] = it.file_id;
                    sh_dir_ib[sh_dir_len] = ib[iba_pkg::BLK_W-1:0];
                    sh_dir_len++;
                    sh_used += need + 1;
                end
            end
            iba_pkg::ACT_DELETE: begin
                pos = dir_lookup(it.file_id);
                if (pos < 0) begin
                    push_rsp(iba_pkg::ST_REJECT, 0, 0, 1'b1);
                end else begin
                    ib = sh_dir_ib[pos];
                    for (int i = 0; i < int'(sh_count[ib]); i++) begin
                        sh_occ[sh_index[ib][i]] = 1'b0;
                    end
                    sh_used -= sh_count[ib] + 1;
                    sh_count[ib] = 0;
                    sh_occ[ib] = 1'b0;
                    for (int i = pos; i + 1 < int'(sh_dir_len); i++) begin
                        sh_key[i] = sh_key[i+1];
                        sh_dir_ib[i] = sh_dir_ib[i+1];
                    end
                    sh_dir_len--;
                    push_rsp(iba_pkg::ST_OK, 0, 0, 1'b1);
                end
            end
            iba_pkg::ACT_SEEK: begin
                pos = dir_lookup(it.file_id);
                if (pos < 0) begin
                    push_rsp(iba_pkg::ST_REJECT, 0, 0, 1'b1);
                end else begin
                    ib = sh_dir_ib[pos];
                    if (int'(it.block_number) >= int'(sh_count[ib])) begin
                        push_rsp(iba_pkg::ST_REJECT, 0, 0, 1'b1);
                    end else begin
                        push_rsp(iba_pkg::ST_OK, sh_index[ib][it.block_number], 0, 1'b1);
                    end
                end
            end
            iba_pkg::ACT_LIST_FILE: begin
                if (sh_dir_len == 0) begin
                    push_rsp(iba_pkg::ST_EMPTY, 0, 0, 1'b1);
                end else begin
                    for (int i = int'(sh_dir_len); i > 0; i--) begin
                        push_rsp(iba_pkg::ST_OK, 0, sh_key[i-1], i == 1);
                    end
                end
            end
            iba_pkg::ACT_LIST_OCC: begin
                lastpos = -1;
                for (int i = 0; i < N_BLK; i++) begin
                    if (sh_occ[i]) begin
                        lastpos = i;
                    end
                end
                if (lastpos < 0) begin
                    push_rsp(iba_pkg::ST_EMPTY, 0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < N_BLK; i++) begin
                        if (sh_occ[i]) begin
                            push_rsp(iba_pkg::ST_OK, i, 0, i == lastpos);
                        end
                    end
                end
            end
            iba_pkg::ACT_CLEAR: begin
                clear_shadow();
                push_rsp(iba_pkg::ST_OK, 0, 0, 1'b1);
            end
            default: begin
                push_rsp(iba_pkg::ST_REJECT, 0, 0, 1'b1);
            end
        endcase
    endfunction

    // Result checking, request prediction, seed tracking and the watchdog share the same
    // always process, clocked on the rising edge, so that the order among them is fixed.
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            stall_cnt = 0;
            clear_shadow();
            sh_lfsr = iba_pkg::LFSR_W'(1);
        end else begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    report("unexpected result, status", rsp_ch.status, 0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        report("status", rsp_ch.status, want.status);
                    end
                    if (rsp_ch.block_index !== want.block_index) begin
                        report("block_index", rsp_ch.block_index, want.block_index);
                    end
                    if (rsp_ch.file_out !== want.file_out) begin
                        report("file_out", rsp_ch.file_out, want.file_out);
                    end
                    if (rsp_ch.last !== want.last) begin
                        report("last", rsp_ch.last, want.last);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                predict_allocation('{req_ch.action, req_ch.file_id, req_ch.file_size,
                                     req_ch.block_number});
            end
            // A seed write reloads the generator at once; zero would load as one.
            if (cfg_ch.valid && cfg_ch.ready) begin
                sh_lfsr = (cfg_ch.lfsr_seed == '0) ? iba_pkg::LFSR_W'(1) : cfg_ch.lfsr_seed;
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                    (cfg_ch.valid && cfg_ch.ready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
            end
            if (stall_cnt >= STALL_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Request driver: offers the next pending request after each accepted one,
    // with random gaps.
    always @(negedge i_clk) begin
        t_req_item it;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                it = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.action <= it.action;
                req_ch.file_id <= it.file_id;
                req_ch.file_size <= it.file_size;
                req_ch.block_number <= it.block_number;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt = 0;
            hold_taken = 1'b0;
        end else begin
            if (hold_start && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic queue_req(logic [iba_pkg::ACT_W-1:0] act, logic [iba_pkg::ID_W-1:0] id,
                             logic [iba_pkg::SIZE_W-1:0] size,
                             logic [iba_pkg::BLK_W-1:0] bn);
        t_req_item it;
        it = '{act, id, size, bn};
        pending_reqs = {pending_reqs, it};
    endtask

    task automatic write_seed(logic [iba_pkg::LFSR_W-1:0] seed);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.lfsr_seed <= seed;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic drain();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic logic [iba_pkg::ID_W-1:0] pool_id();
        return id_pool[$urandom_range(0, POOL_SZ - 1)];
    endfunction

    // Mostly small files so that the disk turns over, some large and some huge.
    function automatic logic [iba_pkg::SIZE_W-1:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return iba_pkg::SIZE_W'($urandom_range(0, 20));
        end else if (r < 90) begin
            return iba_pkg::SIZE_W'($urandom_range(0, 255));
        end
        return iba_pkg::SIZE_W'($urandom);
    endfunction

    task automatic queue_random(int unsigned count);
        int unsigned made;
        int unsigned r;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // Burst of tiny adds that runs the directory into its limit.
                for (int i = 0; i < N_DIR + 1; i++) begin
                    queue_req(iba_pkg::ACT_ADD, pool_id(),
                              iba_pkg::SIZE_W'($urandom_range(0, 8)), '0);
                end
                made += N_DIR + 1;
            end else if (r < 14) begin
                queue_req(iba_pkg::ACT_CLEAR, iba_pkg::ID_W'($urandom),
                          iba_pkg::SIZE_W'($urandom), iba_pkg::BLK_W'($urandom));
                made++;
            end else if (r < 16) begin
                queue_req(($urandom_range(0, 1) != 0) ? ACT_RSVD_HI : ACT_RSVD_LO,
                          pool_id(), iba_pkg::SIZE_W'($urandom), iba_pkg::BLK_W'($urandom));
                made++;
            end else if (r < 40) begin
                queue_req(iba_pkg::ACT_ADD, pool_id(), rand_size(), iba_pkg::BLK_W'($urandom));
                made++;
            end else if (r < 55) begin
                queue_req(iba_pkg::ACT_DELETE, pool_id(), iba_pkg::SIZE_W'($urandom),
                          iba_pkg::BLK_W'($urandom));
                made++;
            end else if (r < 75) begin
                queue_req(iba_pkg::ACT_SEEK, pool_id(), iba_pkg::SIZE_W'($urandom),
                          ($urandom_range(0, 9) < 6) ? iba_pkg::BLK_W'($urandom_range(0, 7))
                                                     : iba_pkg::BLK_W'($urandom));
                made++;
            end else if (r < 87) begin
                queue_req(iba_pkg::ACT_LIST_FILE, pool_id(), iba_pkg::SIZE_W'($urandom),
                          iba_pkg::BLK_W'($urandom));
                made++;
            end else begin
                queue_req(iba_pkg::ACT_LIST_OCC, pool_id(), iba_pkg::SIZE_W'($urandom),
                          iba_pkg::BLK_W'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        int unsigned tx_pct[3];
        int unsigned rx_pct[3];
        logic [iba_pkg::LFSR_W-1:0] seeds[3];
        tx_pct = '{8, 69, 0};
        rx_pct = '{69, 8, 0};
        seeds = '{iba_pkg::LFSR_W'(1), iba_pkg::LFSR_W'(16'hFFFF),
                  iba_pkg::LFSR_W'($urandom_range(1, 65535))};
        errors = 0;
        tx_idle_pct = tx_pct[0];
        rx_idle_pct = rx_pct[0];
        hold_start = 1'b0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = '0;
        req_ch.file_id = '0;
        req_ch.file_size = '0;
        req_ch.block_number = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.lfsr_seed = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            @(posedge i_clk);
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            write_seed(seeds[ph]);
            for (int i = 0; i < POOL_SZ; i++) begin
                id_pool[i] = iba_pkg::ID_W'($urandom);
            end
            id_pool[0] = '0;
            id_pool[1] = '1;
            if (ph == 0) begin
                // Directed opening: empty lists, extremes, duplicates, files too large for the free space.
                queue_req(iba_pkg::ACT_LIST_FILE, '0, '0, '0);
                queue_req(iba_pkg::ACT_LIST_OCC, '1, '1, '1);
                queue_req(iba_pkg::ACT_DELETE, '1, '0, '0);
                queue_req(iba_pkg::ACT_SEEK, '0, '0, '0);
                queue_req(iba_pkg::ACT_ADD, '0, '0, '0);
                queue_req(iba_pkg::ACT_ADD, '1, iba_pkg::SIZE_W'(1), '1);
                queue_req(iba_pkg::ACT_ADD, '1, iba_pkg::SIZE_W'(8), '0);
                queue_req(iba_pkg::ACT_SEEK, '1, '0, '0);
                queue_req(iba_pkg::ACT_SEEK, '1, '0, iba_pkg::BLK_W'(1));
                queue_req(iba_pkg::ACT_SEEK, '0, '0, '0);
                queue_req(iba_pkg::ACT_ADD, iba_pkg::ID_W'(16'h1234), '1, '0);
                queue_req(iba_pkg::ACT_ADD, iba_pkg::ID_W'(16'h5A5A), iba_pkg::SIZE_W'(244), '0);
                queue_req(iba_pkg::ACT_ADD, iba_pkg::ID_W'(16'hA5A5), '0, '0);
                queue_req(iba_pkg::ACT_SEEK, iba_pkg::ID_W'(16'h5A5A), '0, iba_pkg::BLK_W'(60));
                queue_req(iba_pkg::ACT_SEEK, iba_pkg::ID_W'(16'h5A5A), '0, '1);
                queue_req(iba_pkg::ACT_LIST_OCC, '0, '0, '0);
                queue_req(iba_pkg::ACT_LIST_FILE, '0, '0, '0);
                queue_req(ACT_RSVD_LO, '1, '1, '1);
                queue_req(ACT_RSVD_HI, '0, '0, '0);
                queue_req(iba_pkg::ACT_DELETE, iba_pkg::ID_W'(16'h5A5A), '0, '0);
                queue_req(iba_pkg::ACT_DELETE, '0, '0, '0);
                queue_req(iba_pkg::ACT_LIST_FILE, '0, '0, '0);
                queue_req(iba_pkg::ACT_CLEAR, '1, '1, '1);
                queue_req(iba_pkg::ACT_LIST_OCC, '0, '0, '0);
            end
            if (ph == 2) begin
                // Long receiver hold-off while requests keep coming, to back the block up.
                hold_start = 1'b1;
            end
            queue_random(32);
            drain();
        end

        if (expected_rsps.size() != 0) begin
            report("results still expected", 0, expected_rsps.size());
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
